/* design/crrc_pkg.sv */
// crrc_pkg: types, codes and constants shared by the command ring
// reserve/commit unit. No dependencies.
`default_nettype none
package crrc_pkg;

	localparam int unsigned OFS_W = 23;
	localparam int unsigned ARITH_W = 26;
	localparam logic [OFS_W-1:0] RING_BYTES = 23'd4194304;
	localparam logic [OFS_W-1:0] RING_START_RST = 23'd1024;
	localparam logic [OFS_W-1:0] RING_END_RST = 23'd65536;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_UNALIGNED = 3'd2,
		ST_PENDING   = 3'd3,
		ST_FULL      = 3'd4,
		ST_NONE      = 3'd5
	} status_t;

	typedef enum logic {
		ACT_RESERVE = 1'b0,
		ACT_COMMIT  = 1'b1
	} action_t;

	localparam logic [1:0] CFG_RING_START = 2'd0;
	localparam logic [1:0] CFG_RING_END   = 2'd1;
	localparam logic [1:0] CFG_CAPABLE    = 2'd2;

	typedef struct packed {
		logic [OFS_W-1:0] ring_start;
		logic [OFS_W-1:0] ring_end;
		logic             capable;
	} cfg_t;

	typedef struct packed {
		logic [OFS_W-1:0] wp;
		logic [OFS_W-1:0] pending;
		logic             bounce;
	} ring_state_t;

	typedef struct packed {
		action_t          action;
		logic [OFS_W-1:0] byte_count;
		logic [OFS_W-1:0] stop_offset;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic             use_bounce;
		logic [OFS_W-1:0] write_offset;
		logic [OFS_W-1:0] reserved_word;
		logic [OFS_W-1:0] first_chunk_offset;
		logic [OFS_W-1:0] first_chunk_length;
		logic [OFS_W-1:0] second_chunk_length;
		logic [OFS_W-1:0] next_write_offset;
	} result_t;

endpackage
`default_nettype wire

/* design/crrc_cfg_regs.sv */
// crrc_cfg_regs: ring bound and capability registers behind the write port.
// Depends on crrc_pkg.
`default_nettype none
module crrc_cfg_regs
	import crrc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [OFS_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output logic                  start_wr
);

	logic [OFS_W-1:0] ring_start_q;
	logic [OFS_W-1:0] ring_end_q;
	logic             capable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_start_q <= RING_START_RST;
			ring_end_q   <= RING_END_RST;
			capable_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RING_START: ring_start_q <= cfg_data;
				CFG_RING_END:   ring_end_q   <= cfg_data;
				CFG_CAPABLE:    capable_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign start_wr = cfg_we && (cfg_index == CFG_RING_START);

	assign cfg.ring_start = ring_start_q;
	assign cfg.ring_end   = ring_end_q;
	assign cfg.capable    = capable_q;

endmodule
`default_nettype wire

/* design/crrc_eval.sv */
// crrc_eval: reserve/commit decision for one transaction against the ring state.
// Purely combinational. Depends on crrc_pkg.
`default_nettype none
module crrc_eval
	import crrc_pkg::*;
(
	input  wire item_t       item,
	input  wire cfg_t        cfg,
	input  wire ring_state_t cur,
	output result_t          res,
	output ring_state_t      nxt
);

	always_comb begin
		logic signed [ARITH_W-1:0] n, st, mn, mx, wp, nx, room, first, span;
		logic [OFS_W-1:0]          eff_end;
		logic                      inplace, bounce;

		eff_end = (cfg.ring_end > RING_BYTES) ? RING_BYTES : cfg.ring_end;
		n    = $signed({3'b000, item.byte_count});
		st   = $signed({3'b000, item.stop_offset});
		mn   = $signed({3'b000, cfg.ring_start});
		mx   = $signed({3'b000, eff_end});
		wp   = $signed({3'b000, cur.wp});
		span = mx - mn;
		nx   = wp + n;
		room = mx - wp;
		if (room < 0)
			room = '0;
		first   = (n < room) ? n : room;
		inplace = 1'b0;
		bounce  = 1'b0;

		res = '0;
		res.status = ST_OK;
		nxt = cur;

		if (item.action == ACT_RESERVE) begin
			if (n > span) begin
				res.status = ST_TOO_LARGE;
			end else if (item.byte_count[1:0] != 2'b00) begin
				res.status = ST_UNALIGNED;
			end else if (cur.pending != '0) begin
				res.status = ST_PENDING;
			end else begin
				if (wp >= st) begin
					if (nx < mx || (nx == mx && st > mn))
						inplace = 1'b1;
					else if (!((mx - wp) + (st - mn) <= n))
						bounce = 1'b1;
				end else if (nx < st) begin
					inplace = 1'b1;
				end
				if (inplace) begin
					if (cfg.capable || n <= 4) begin
						nxt.bounce = 1'b0;
						nxt.pending = item.byte_count;
						res.write_offset = cur.wp;
						res.reserved_word = cfg.capable ? item.byte_count : '0;
					end else begin
						bounce = 1'b1;
					end
				end
				if (bounce) begin
					nxt.bounce = 1'b1;
					nxt.pending = item.byte_count;
					res.use_bounce = 1'b1;
				end
				if (!inplace && !bounce)
					res.status = ST_FULL;
			end
		end else begin
			if (cur.pending == '0) begin
				res.status = ST_NONE;
			end else begin
				nxt.pending = '0;
				if (cur.bounce) begin
					res.first_chunk_offset  = cur.wp;
					res.first_chunk_length  = first[OFS_W-1:0];
					res.second_chunk_length = OFS_W'(n - first);
				end
				if (nx >= mx)
					nx = nx - span;
				nxt.wp = nx[OFS_W-1:0];
			end
		end
		res.next_write_offset = nxt.wp;
	end

endmodule
`default_nettype wire

/* design/command_ring_reserve_commit_unit.sv */
// Command ring reserve/commit unit: top level with input stage, ring state,
// and result register. Depends on crrc_pkg, crrc_cfg_regs, crrc_eval.
//
// Usage:
//  s_* channel carries reserve (tuser=0) and commit (tuser=1) transactions;
//  m_* channel returns exactly one result per transaction, in order.
//  The input register captures a transaction at the accepting edge; the decision
//  logic then updates the ring state and loads the result register, which
//  raises m_tvalid. Throughput is one transaction per cycle while the receiver
//  keeps m_tready high; the state update lands in the same cycle the result is
//  registered, so the next transaction sees it with no bubble.
//  When the receiver stalls, the result register holds and the input stage
//  keeps one more transaction; s_tready drops only when both are full.
//  Reset clears both stages, loads ring start 1024, ring end 65536,
//  capability off, write pointer 1024, and no pending reservation.
//  Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once; the user
//  must make them only while no transaction is in flight, which the block itself
//  does not enforce; a write of the ring start also reloads the write pointer.
`default_nettype none
module command_ring_reserve_commit_unit
	import crrc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [47:0]  s_tdata,   // byte_count[22:0], stop_offset[45:23], zero pad
	input  wire logic         s_tuser,   // action: 0 reserve, 1 commit
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [143:0]      m_tdata,   // use_bounce[0], write_offset[23:1],
	                                     // reserved_word[46:24], first_chunk_offset[69:47],
	                                     // first_chunk_length[92:70],
	                                     // second_chunk_length[115:93],
	                                     // next_write_offset[138:116], zero pad
	output logic [2:0]        m_tuser,   // status
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [22:0]  cfg_data
);

	cfg_t        cfg;
	logic        start_wr;
	ring_state_t state_q;
	ring_state_t state_nxt;
	item_t       item_s1;
	logic        valid_s1;
	result_t     res;
	result_t     res_s2;
	logic        valid_s2;
	logic        adv;

	crrc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.start_wr (start_wr)
	);

	crrc_eval u_eval (
		.item(item_s1),
		.cfg (cfg),
		.cur (state_q),
		.res (res),
		.nxt (state_nxt)
	);

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action      <= action_t'(s_tuser);
			item_s1.byte_count  <= s_tdata[22:0];
			item_s1.stop_offset <= s_tdata[45:23];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.wp      <= RING_START_RST;
			state_q.pending <= '0;
			state_q.bounce  <= 1'b0;
		end else if (start_wr) begin
			state_q.wp <= cfg_data;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.status;
	assign m_tdata  = {5'b00000,
		res_s2.next_write_offset,
		res_s2.second_chunk_length,
		res_s2.first_chunk_length,
		res_s2.first_chunk_offset,
		res_s2.reserved_word,
		res_s2.write_offset,
		res_s2.use_bounce};

`ifndef NO_ASSERTIONS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2))
		else $error("input stall without both stages full");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= ST_NONE))
		else $error("status code out of range");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |->
		(m_tdata[0] == 1'b0 && m_tdata[46:1] == '0 && m_tdata[115:47] == '0))
		else $error("error result carries payload");

	a_pending_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pending != '0 && !adv) |=> $stable(state_q.pending))
		else $error("pending reservation changed without a transaction");
`endif

endmodule
`default_nettype wire

/* tb/tb_command_ring_reserve_commit_unit.sv */
// Self-checking testbench for command_ring_reserve_commit_unit: reserve and commit
// transactions over several ring settings, checked against a cycle-free ring predictor.
// Depends on crrc_pkg and the unit under test.
module tb_command_ring_reserve_commit_unit;
	import crrc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_LIMIT = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_RING_START;
	logic [22:0] cfg_data = '0;

	// predictor copy of the ring registers and state
	logic [22:0] cfg_start = RING_START_RST;
	logic [22:0] cfg_end = RING_END_RST;
	logic cfg_cap = 1'b0;
	logic [22:0] ring_wp = RING_START_RST;
	logic [22:0] ring_pending = '0;
	logic ring_bounce = 1'b0;

	item_t cmds_to_send[$];
	result_t results_due[$];
	item_t offered;
	item_t nxt;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int errors = 0;
	int settings = 1;
	int status_seen[0:7];
	logic calm = 1'b0;

	command_ring_reserve_commit_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t ring_step(item_t it);
		result_t r;
		longint n, stop, lo, hi, wp, room, first, nx;
		logic in_place, to_bounce;
		r = '0;
		n = it.byte_count;
		stop = it.stop_offset;
		lo = cfg_start;
		hi = (cfg_end > RING_BYTES) ? RING_BYTES : cfg_end;
		wp = ring_wp;
		if (it.action == ACT_RESERVE) begin
			if (n > hi - lo) begin
				r.status = ST_TOO_LARGE;
			end else if (n % 4 != 0) begin
				r.status = ST_UNALIGNED;
			end else if (ring_pending != 0) begin
				r.status = ST_PENDING;
			end else begin
				in_place = 1'b0;
				to_bounce = 1'b0;
				if (wp >= stop) begin
					if (wp + n < hi || (wp + n == hi && stop > lo))
						in_place = 1'b1;
					else if ((hi - wp) + (stop - lo) > n)
						to_bounce = 1'b1;
				end else if (wp + n < stop) begin
					in_place = 1'b1;
				end
				if (in_place) begin
					// multiword commands need device support to stay in place
					if (cfg_cap || n <= 4) begin
						ring_bounce = 1'b0;
						ring_pending = n[22:0];
						r.write_offset = wp[22:0];
						r.reserved_word = cfg_cap ? n[22:0] : 23'd0;
					end else begin
						to_bounce = 1'b1;
					end
				end
				if (to_bounce) begin
					ring_bounce = 1'b1;
					ring_pending = n[22:0];
					r.use_bounce = 1'b1;
				end
				if (!in_place && !to_bounce)
					r.status = ST_FULL;
			end
		end else if (ring_pending == 0) begin
			r.status = ST_NONE;
		end else begin
			ring_pending = '0;
			if (ring_bounce) begin
				room = (hi - wp < 0) ? 0 : hi - wp;
				first = (n < room) ? n : room;
				r.first_chunk_offset = wp[22:0];
				r.first_chunk_length = first[22:0];
				r.second_chunk_length = 23'(n - first);
			end
			nx = wp + n;
			if (nx >= hi)
				nx -= hi - lo;
			ring_wp = nx[22:0];
		end
		r.next_write_offset = ring_wp;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (errors < PRINT_LIMIT)
			$display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [22:0] got, logic [22:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (results_due.size() == 0) begin
			report_mismatch("result arrived with no transaction outstanding");
		end else begin
			want = results_due.pop_front();
			check_field("status", 23'(got.status), 23'(want.status));
			check_field("use_bounce", 23'(got.use_bounce), 23'(want.use_bounce));
			check_field("write_offset", got.write_offset, want.write_offset);
			check_field("reserved_word", got.reserved_word, want.reserved_word);
			check_field("first_chunk_offset", got.first_chunk_offset,
				want.first_chunk_offset);
			check_field("first_chunk_length", got.first_chunk_length,
				want.first_chunk_length);
			check_field("second_chunk_length", got.second_chunk_length,
				want.second_chunk_length);
			check_field("next_write_offset", got.next_write_offset,
				want.next_write_offset);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				results_due.push_back(ring_step(offered));
				items_sent <= items_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (cmds_to_send.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					s_tvalid <= 1'b0;
					send_gap <= $urandom_range(0, 18);
				end else begin
					nxt = cmds_to_send.pop_front();
					offered <= nxt;
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, nxt.stop_offset, nxt.byte_count};
					s_tuser <= nxt.action;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result('{status: status_t'(m_tuser), use_bounce: m_tdata[0],
					write_offset: m_tdata[23:1], reserved_word: m_tdata[46:24],
					first_chunk_offset: m_tdata[69:47],
					first_chunk_length: m_tdata[92:70],
					second_chunk_length: m_tdata[115:93],
					next_write_offset: m_tdata[138:116]});
				status_seen[m_tuser]++;
				results_seen <= results_seen + 1;
			end
			// long back-pressure so the unit fills and drops s_tready
			if (m_tvalid && m_tready && (results_seen == 149 || results_seen == 299)) begin
				m_tready <= 1'b0;
				hold_left <= 60;
			end else if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (recv_gap != 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				recv_gap <= $urandom_range(0, 18);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic add_cmd(action_t act, logic [22:0] count, logic [22:0] stop);
		cmds_to_send.push_back('{action: act, byte_count: count, stop_offset: stop});
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (cmds_to_send.size() != 0 || s_tvalid || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_ring(logic [22:0] start_ofs, logic [22:0] end_ofs, logic cap);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_RING_END;
		cfg_data <= end_ofs;
		@(posedge clk);
		cfg_index <= CFG_CAPABLE;
		cfg_data <= {22'd0, cap};
		@(posedge clk);
		cfg_index <= CFG_RING_START;
		cfg_data <= start_ofs;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_start = start_ofs;
		cfg_end = end_ofs;
		cfg_cap = cap;
		ring_wp = start_ofs;
		settings++;
		@(negedge clk);
	endtask

	task automatic queue_traffic(int count);
		int span, added, kind, n, n2;
		logic [22:0] stop;
		span = int'((cfg_end > RING_BYTES) ? RING_BYTES : cfg_end) - int'(cfg_start);
		added = 0;
		while (added < count) begin
			kind = $urandom_range(0, 9);
			if (span > 0 && $urandom_range(0, 4) != 0)
				stop = cfg_start + 23'($urandom_range(0, span));
			else
				stop = 23'($urandom);
			if (span < 4)
				n = 4 * $urandom_range(0, 2);
			else if ($urandom_range(0, 15) == 0)
				n = span - span % 4;
			else
				n = 4 * $urandom_range(0, (span / 4 < 40) ? span / 4 : 40);
			n2 = 4 * $urandom_range(0, 16);
			if (kind <= 6) begin
				add_cmd(ACT_RESERVE, 23'(n), stop);
				add_cmd(ACT_COMMIT, ($urandom_range(0, 5) == 0) ? 23'(n2) : 23'(n), stop);
				added += 2;
			end else if (kind == 7) begin
				add_cmd(ACT_RESERVE, 23'(n), stop);
				add_cmd(ACT_RESERVE, 23'(n2), 23'($urandom));
				add_cmd(ACT_COMMIT, 23'(n), stop);
				added += 3;
			end else if (kind == 8) begin
				add_cmd(ACT_RESERVE, 23'($urandom), stop);
				added += 1;
			end else begin
				add_cmd(ACT_COMMIT, ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'(n2),
					23'($urandom));
				added += 1;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset ring: start 1024, end 65536, no in-place multiword support
		add_cmd(ACT_COMMIT, 23'd8, 23'd0);
		add_cmd(ACT_RESERVE, 23'd4194304, 23'd0);
		add_cmd(ACT_RESERVE, 23'h7fffff, 23'h7fffff);
		add_cmd(ACT_RESERVE, 23'd6, 23'd0);
		add_cmd(ACT_RESERVE, 23'd0, 23'd0);
		add_cmd(ACT_COMMIT, 23'd0, 23'd0);
		add_cmd(ACT_RESERVE, 23'd4, 23'd0);
		add_cmd(ACT_RESERVE, 23'd8, 23'd0);
		add_cmd(ACT_COMMIT, 23'd4, 23'd0);
		add_cmd(ACT_RESERVE, 23'd8, 23'd1032);
		add_cmd(ACT_RESERVE, 23'd4, 23'd1036);
		add_cmd(ACT_COMMIT, 23'd4, 23'd0);
		add_cmd(ACT_RESERVE, 23'd64, 23'd0);
		add_cmd(ACT_COMMIT, 23'd64, 23'd0);
		add_cmd(ACT_RESERVE, 23'd4, 23'd0);
		add_cmd(ACT_COMMIT, 23'd64400, 23'd0);
		add_cmd(ACT_RESERVE, 23'd64, 23'd2048);
		add_cmd(ACT_COMMIT, 23'd64, 23'd0);
		add_cmd(ACT_RESERVE, 23'd4, 23'h7fffff);
		add_cmd(ACT_COMMIT, 23'd64488, 23'd0);
		add_cmd(ACT_RESERVE, 23'd4, 23'd0);
		add_cmd(ACT_COMMIT, 23'd64508, 23'd0);
		add_cmd(ACT_RESERVE, 23'd4, 23'd2000);
		add_cmd(ACT_COMMIT, 23'd4, 23'd0);
		add_cmd(ACT_RESERVE, 23'd64512, 23'd1024);
		wait_idle();

		program_ring(23'd0, 23'd64, 1'b1);
		queue_traffic(100);
		wait_idle();
		program_ring(23'd4096, 23'd4194304, 1'b0);
		queue_traffic(80);
		wait_idle();
		program_ring(23'd4194300, 23'h7fffff, 1'b1);
		queue_traffic(70);
		wait_idle();
		// end below start, then empty rings
		program_ring(23'd2000, 23'd1000, 1'b0);
		queue_traffic(20);
		wait_idle();
		program_ring(23'd0, 23'd0, 1'b1);
		queue_traffic(15);
		wait_idle();
		program_ring(23'd512, 23'd512, 1'b0);
		queue_traffic(15);
		wait_idle();

		calm = 1'b1;
		program_ring(23'd256, 23'd1280, 1'($urandom_range(0, 1)));
		queue_traffic(150);
		wait_idle();
		repeat (4) @(posedge clk);

		$display("Sent %0d transactions and checked %0d results over %0d ring settings",
			items_sent, results_seen, settings);
		$display("Status tally ok/large/unaligned/pending/full/none: %0d/%0d/%0d/%0d/%0d/%0d",
			status_seen[ST_OK], status_seen[ST_TOO_LARGE], status_seen[ST_UNALIGNED],
			status_seen[ST_PENDING], status_seen[ST_FULL], status_seen[ST_NONE]);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
